// ===== rtl/binary_edge_detector_assert.svh =====
// Assertion macros for the edge detector checker.
`ifndef BINARY_EDGE_DETECTOR_ASSERT_SVH
`define BINARY_EDGE_DETECTOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define BED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== rtl/bed_pkg.sv =====
// Types and constants for the binary edge detector.
`default_nettype none

package bed_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned FW_W       = 9;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned MIN_WIDTH  = 2;

  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [FW_W-1:0]       frame_width_t;
  typedef logic [THR_W-1:0]      threshold_t;

  // Register indexes
  localparam cfg_idx_t CFG_FRAME_WIDTH      = 1'd0;
  localparam cfg_idx_t CFG_BRIGHT_THRESHOLD = 1'd1;

  // Register reset values
  localparam frame_width_t FRAME_WIDTH_RST = 9'd256;
  localparam threshold_t   THRESHOLD_RST   = 10'd384;

  // Request kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Result codes
  localparam chan_t EDGE_MARK = 8'd0;
  localparam chan_t EDGE_NONE = 8'd255;

  // One pixel request as held in the input register
  typedef struct packed {
    logic  mode;
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  frame_end;
  } pix_t;

endpackage

`default_nettype wire

// ===== rtl/bed_if.sv =====
// Request and result channel interfaces of the binary edge detector.
`default_nettype none

interface bed_pix_if;
  import bed_pkg::*;

  logic  valid;
  logic  ready;
  logic  mode;
  chan_t red;
  chan_t green;
  chan_t blue;
  logic  frame_end;

  modport source (output valid, mode, red, green, blue, frame_end, input ready);
  modport sink   (input valid, mode, red, green, blue, frame_end, output ready);
endinterface

interface bed_res_if;
  import bed_pkg::*;

  logic  valid;
  logic  ready;
  chan_t edge_value;
  logic  frame_done;

  modport source (output valid, edge_value, frame_done, input ready);
  modport sink   (input valid, edge_value, frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/binary_edge_detector.sv =====
// Binary edge detector: threshold RGB pixels and mark edges against their neighbours.
//
// Usage:
//   pix_i takes pixel requests in raster order (mode pixel) and, after the
//   request flagged frame_end, one flush request per column of the last row.
//   res_o gives edge_value (0 on an edge, 255 elsewhere) and frame_done on
//   the last flush result. The first row of a frame gives no results; each
//   later pixel gives the result for the pixel above it.
//   The user must write registers frame_width and bright_threshold through the
//   cfg_* port only while the block is idle; the block does not enforce this.
// Timing:
//   One request per cycle sustained while results are taken. A request is held
//   in the input register and its result in the result register. The line
//   store is read ahead at the next column, with bypass of the write under way.
// Reset:
//   Registers return to 256 and 384, the line reads as all black through a
//   fill count, so no clearing pass is needed.
// Back-pressure:
//   A stalled result holds in the result register; the input register still
//   takes one more request, then ready drops until the result is taken.
`default_nettype none

module binary_edge_detector #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  bed_pkg::cfg_idx_t   cfg_idx_i,
  input  bed_pkg::cfg_data_t  cfg_data_i,
  bed_pix_if.sink             pix_i,
  bed_res_if.source           res_o
);
  import bed_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW = (CW > FW_W) ? CW : FW_W;

  typedef logic [CW-1:0] col_t;
  typedef logic [AW-1:0] addr_t;

  // Clamp the programmed width to the supported range
  function automatic col_t clamp_width(input frame_width_t fw);
    logic [WW-1:0] fwx;
    col_t          w;
    fwx = WW'(fw);
    if (fwx < WW'(MIN_WIDTH)) begin
      w = CW'(MIN_WIDTH);
    end else if (fwx > WW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(fwx);
    end
    return w;
  endfunction

  frame_width_t fw_q, fw_d;
  threshold_t   thr_q, thr_d;
  col_t         width_cur, width_nx;

  logic s1_valid_q, s1_valid_d;
  pix_t s1_q;
  logic s1_adv;

  col_t col_q, col_d, col_eff, col_inc, nx_eff, nx_inc;
  col_t fill_q, fill_d;
  logic flushing_q, flushing_d;
  logic past_q, past_d;

  logic [SUM_W-1:0] sum;
  logic             pix_bit;
  logic             is_flush;
  logic             has_right, last_col, diff_right;
  logic             wr_en;
  addr_t            wr_addr, rd0_addr, rd1_addr;

  logic  line_mem_q [MAX_WIDTH];
  logic  rd0_raw_q, rd1_raw_q;
  logic  fwd0_q, fwd1_q, fwd_bit_q, vld0_q, vld1_q;
  logic  rd0, rd1;

  logic  res_load, res_edge, res_done;
  logic  res_valid_q, res_valid_d;
  chan_t res_value_q;
  logic  res_done_q;

  // Decode register writes
  always_comb begin
    fw_d  = fw_q;
    thr_d = thr_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:      fw_d  = cfg_data_i[FW_W-1:0];
        CFG_BRIGHT_THRESHOLD: thr_d = cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_cur = clamp_width(fw_q);
  assign width_nx  = clamp_width(fw_d);

  // Advance the input register when the result register can take its output
  assign s1_adv      = s1_valid_q && (!res_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_i.valid && pix_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Restart the column when the width has shrunk below it
  assign col_eff    = (col_q >= width_cur) ? '0 : col_q;
  assign col_inc    = col_eff + CW'(1);
  assign has_right  = col_inc < width_cur;
  assign last_col   = !has_right;
  assign rd0        = fwd0_q ? fwd_bit_q : (vld0_q & rd0_raw_q);
  assign rd1        = fwd1_q ? fwd_bit_q : (vld1_q & rd1_raw_q);
  assign diff_right = has_right && (rd1 != rd0);

  // Binarise the pixel
  assign sum      = SUM_W'(s1_q.red) + SUM_W'(s1_q.green) + SUM_W'(s1_q.blue);
  assign pix_bit  = sum > thr_q;
  assign is_flush = (s1_q.mode == MODE_FLUSH);
  assign wr_addr  = col_eff[AW-1:0];

  // Handle the request in the input register
  always_comb begin
    col_d      = col_q;
    flushing_d = flushing_q;
    past_d     = past_q;
    wr_en      = 1'b0;
    res_load   = 1'b0;
    res_edge   = 1'b0;
    res_done   = 1'b0;
    if (s1_adv) begin
      col_d = col_eff;
      if (is_flush) begin
        if (flushing_q) begin
          res_load = 1'b1;
          res_edge = diff_right;
          res_done = last_col;
          if (last_col) begin
            col_d      = '0;
            flushing_d = 1'b0;
            past_d     = 1'b0;
          end else begin
            col_d = col_inc;
          end
        end
      end else if (!flushing_q) begin
        wr_en = 1'b1;
        if (past_q) begin
          res_load = 1'b1;
          res_edge = (rd0 != pix_bit) || diff_right;
        end
        if (s1_q.frame_end) begin
          flushing_d = 1'b1;
          col_d      = '0;
        end else if (last_col) begin
          col_d  = '0;
          past_d = 1'b1;
        end else begin
          col_d = col_inc;
        end
      end
    end
  end

  // Extend the written prefix of the line store
  always_comb begin
    fill_d = fill_q;
    if (wr_en && (col_eff == fill_q)) begin
      fill_d = fill_q + CW'(1);
    end
  end

  // Prefetch addresses for the column the next request will use
  assign nx_eff   = (col_d >= width_nx) ? '0 : col_d;
  assign nx_inc   = nx_eff + CW'(1);
  assign rd0_addr = nx_eff[AW-1:0];
  assign rd1_addr = nx_inc[AW-1:0];

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= FRAME_WIDTH_RST;
      thr_q       <= THRESHOLD_RST;
      s1_valid_q  <= 1'b0;
      col_q       <= '0;
      fill_q      <= '0;
      flushing_q  <= 1'b0;
      past_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      fw_q        <= fw_d;
      thr_q       <= thr_d;
      s1_valid_q  <= s1_valid_d;
      col_q       <= col_d;
      fill_q      <= fill_d;
      flushing_q  <= flushing_d;
      past_q      <= past_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      s1_q <= '{mode: pix_i.mode, red: pix_i.red, green: pix_i.green,
                blue: pix_i.blue, frame_end: pix_i.frame_end};
    end
  end

  // Line store: one write, two registered reads, bypass of the same-cycle write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem_q[wr_addr] <= pix_bit;
    end
    rd0_raw_q <= line_mem_q[rd0_addr];
    rd1_raw_q <= line_mem_q[rd1_addr];
    fwd0_q    <= wr_en && (wr_addr == rd0_addr);
    fwd1_q    <= wr_en && (wr_addr == rd1_addr);
    fwd_bit_q <= pix_bit;
    vld0_q    <= nx_eff < fill_q;
    vld1_q    <= nx_inc < fill_q;
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_value_q <= res_edge ? EDGE_MARK : EDGE_NONE;
      res_done_q  <= res_done;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.edge_value = res_value_q;
  assign res_o.frame_done = res_done_q;

endmodule

`default_nettype wire

// ===== rtl/bed_checker.sv =====
// Port-level checks for the binary edge detector, bound to the top level.
`default_nettype none
`include "binary_edge_detector_assert.svh"

module bed_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input bed_pkg::chan_t edge_value_i,
  input logic           frame_done_i
);
  import bed_pkg::*;

  // Input stalls only behind a result that is itself stalled
  `BED_ASSERT(a_stall_cause, !in_ready_i |-> (out_valid_i && !out_ready_i), "input stalled without output stall")

  // Hold a stalled result
  `BED_ASSERT(a_res_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(edge_value_i) && $stable(frame_done_i)), "stalled result changed")

  // A frame has at least two flush results, so frame ends never come back to back
  `BED_ASSERT(a_done_spacing, (out_valid_i && out_ready_i && frame_done_i) |=> !(out_valid_i && frame_done_i), "two frame ends in a row")

  // Leave reset empty and ready
  `BED_ASSERT_ALWAYS(a_reset_quiet, $rose(rst_ni) |-> (!out_valid_i && in_ready_i), "not idle after reset")

endmodule

bind binary_edge_detector bed_checker u_bed_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pix_i.valid),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .edge_value_i (res_o.edge_value),
  .frame_done_i (res_o.frame_done)
);

`default_nettype wire
